// ===== design/thruster_mix_slew_limiter_core_macros.svh =====
// assertion macros for the thruster mix slew limiter core
`ifndef THRUSTER_MIX_SLEW_LIMITER_CORE_MACROS_SVH
`define THRUSTER_MIX_SLEW_LIMITER_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define TMSL_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled while reset is asserted
`define TMSL_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// ===== design/tmsl_pkg.sv =====
// shared widths, register codes and arithmetic helpers for the thruster mixer
package tmsl_pkg;

	localparam int AXIS_W  = 12;
	localparam int SUM_W   = 14;
	localparam int SPEED_W = 10;
	localparam int DIFF_W  = 11;
	localparam int LIMIT_W = 9;
	localparam int JERK_W  = 8;
	localparam int MASK_W  = 6;
	localparam int PULSE_W = 11;
	localparam int HELD_N  = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 9;

	localparam logic [PULSE_W-1:0] PULSE_CENTER = 11'd1500;

	localparam logic [LIMIT_W-1:0] SPEED_LIMIT_RST  = 9'd295;
	localparam logic [JERK_W-1:0]  JERK_STEP_RST    = 8'd10;
	localparam logic [MASK_W-1:0]  REVERSE_MASK_RST = 6'd0;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SPEED_LIMIT  = 2'd0,
		REG_JERK_STEP    = 2'd1,
		REG_REVERSE_MASK = 2'd2
	} cfg_reg_t;

	// held speed slots
	localparam int H_A = 0;
	localparam int H_B = 1;
	localparam int H_E = 2;
	localparam int H_F = 3;
	localparam int H_Z = 4;

	// reverse mask bits per motor
	localparam int MOT_A = 0;
	localparam int MOT_B = 1;
	localparam int MOT_C = 2;
	localparam int MOT_D = 3;
	localparam int MOT_E = 4;
	localparam int MOT_F = 5;

	// clamp a mixed sum to plus or minus the limit
	function automatic logic signed [SPEED_W-1:0] clamp_speed(
		input logic signed [SUM_W-1:0] sum,
		input logic [LIMIT_W-1:0]      limit
	);
		logic signed [SUM_W-1:0] lim_pos;
		logic signed [SUM_W-1:0] lim_neg;
		lim_pos = signed'({{(SUM_W-LIMIT_W){1'b0}}, limit});
		lim_neg = -lim_pos;
		if (sum > lim_pos) begin
			return lim_pos[SPEED_W-1:0];
		end else if (sum < lim_neg) begin
			return lim_neg[SPEED_W-1:0];
		end
		return sum[SPEED_W-1:0];
	endfunction

	// move a held speed toward its target by at most one jerk step
	function automatic logic signed [SPEED_W-1:0] slew_speed(
		input logic signed [SPEED_W-1:0] cur,
		input logic signed [SPEED_W-1:0] tgt,
		input logic [JERK_W-1:0]         jerk
	);
		logic signed [DIFF_W-1:0] cur_x;
		logic signed [DIFF_W-1:0] diff;
		logic signed [DIFF_W-1:0] step;
		logic signed [DIFF_W-1:0] moved;
		cur_x = signed'({cur[SPEED_W-1], cur});
		diff  = signed'({tgt[SPEED_W-1], tgt}) - cur_x;
		step  = signed'({{(DIFF_W-JERK_W){1'b0}}, jerk});
		if (diff > step) begin
			moved = cur_x + step;
			return moved[SPEED_W-1:0];
		end else if (diff < -step) begin
			moved = cur_x - step;
			return moved[SPEED_W-1:0];
		end
		return tgt;
	endfunction

	// pulse width around center, wrapping at the pulse width
	function automatic logic [PULSE_W-1:0] pulse_width(
		input logic signed [SPEED_W-1:0] speed,
		input logic                      rev
	);
		logic [PULSE_W-1:0] speed_x;
		speed_x = {{(PULSE_W-SPEED_W){speed[SPEED_W-1]}}, speed};
		return rev ? (PULSE_CENTER - speed_x) : (PULSE_CENTER + speed_x);
	endfunction

endpackage

// ===== design/tmsl_if.sv =====
// handshake channel interfaces: axis commands, pulse results, register writes

interface tmsl_axis_if;
	logic                                     valid;
	logic                                     ready;
	logic signed [tmsl_pkg::AXIS_W-1:0]       axis_x;
	logic signed [tmsl_pkg::AXIS_W-1:0]       axis_y;
	logic signed [tmsl_pkg::AXIS_W-1:0]       axis_z;
	logic signed [tmsl_pkg::AXIS_W-1:0]       axis_r;

	modport source (output valid, axis_x, axis_y, axis_z, axis_r, input ready);
	modport sink (input valid, axis_x, axis_y, axis_z, axis_r, output ready);
endinterface

interface tmsl_pulse_if;
	logic                             valid;
	logic                             ready;
	logic [tmsl_pkg::PULSE_W-1:0]     pulse_a;
	logic [tmsl_pkg::PULSE_W-1:0]     pulse_b;
	logic [tmsl_pkg::PULSE_W-1:0]     pulse_c;
	logic [tmsl_pkg::PULSE_W-1:0]     pulse_d;
	logic [tmsl_pkg::PULSE_W-1:0]     pulse_e;
	logic [tmsl_pkg::PULSE_W-1:0]     pulse_f;

	modport source (output valid, pulse_a, pulse_b, pulse_c, pulse_d, pulse_e, pulse_f,
		input ready);
	modport sink (input valid, pulse_a, pulse_b, pulse_c, pulse_d, pulse_e, pulse_f,
		output ready);
endinterface

interface tmsl_cfg_if;
	logic                                 valid;
	logic                                 ready;
	logic [tmsl_pkg::CFG_IDX_W-1:0]       index;
	logic [tmsl_pkg::CFG_DATA_W-1:0]      data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== design/thruster_mix_slew_limiter_core.sv =====
// thruster mixer with per-item slew limit, one item per cycle while the pulse side accepts
//
//  channel | dir | handshake   | payload
//  cmd     | in  | valid/ready | axis_x, axis_y, axis_z, axis_r (12b signed)
//  pulse   | out | valid/ready | pulse_a .. pulse_f (11b unsigned)
//  cfg     | in  | valid/ready | index (2b), data (9b); always ready
//
// An item is captured in the input register at the accepting edge and is mixed, clamped
// and slewed in one pass into the result register when the result register is free.
// Throughput is one item per cycle while the pulse side is ready, set by the held speed update loop.
// A stalled result holds; the input register still takes one more item.
// Reset clears the held speeds and loads the register defaults.

`include "thruster_mix_slew_limiter_core_macros.svh"

module thruster_mix_slew_limiter_core (
	input  logic          clk,
	input  logic          arst_n,
	tmsl_axis_if.sink     cmd,
	tmsl_pulse_if.source  pulse,
	tmsl_cfg_if.sink      cfg
);

	// configuration registers
	logic [tmsl_pkg::LIMIT_W-1:0] speed_limit_q;
	logic [tmsl_pkg::JERK_W-1:0]  jerk_step_q;
	logic [tmsl_pkg::MASK_W-1:0]  reverse_mask_q;

	// input register
	logic                                valid_s1;
	logic signed [tmsl_pkg::AXIS_W-1:0]  x_s1;
	logic signed [tmsl_pkg::AXIS_W-1:0]  y_s1;
	logic signed [tmsl_pkg::AXIS_W-1:0]  z_s1;
	logic signed [tmsl_pkg::AXIS_W-1:0]  r_s1;

	// held speeds and result register
	logic [tmsl_pkg::HELD_N-1:0][tmsl_pkg::SPEED_W-1:0] held_q;
	logic [tmsl_pkg::HELD_N-1:0][tmsl_pkg::SPEED_W-1:0] held_nxt;
	logic                                out_valid_q;
	logic [tmsl_pkg::PULSE_W-1:0]        pulse_a_q;
	logic [tmsl_pkg::PULSE_W-1:0]        pulse_b_q;
	logic [tmsl_pkg::PULSE_W-1:0]        pulse_c_q;
	logic [tmsl_pkg::PULSE_W-1:0]        pulse_d_q;
	logic [tmsl_pkg::PULSE_W-1:0]        pulse_e_q;
	logic [tmsl_pkg::PULSE_W-1:0]        pulse_f_q;

	logic out_free;
	logic advance;
	logic cmd_take;

	logic signed [tmsl_pkg::SUM_W-1:0] x_w;
	logic signed [tmsl_pkg::SUM_W-1:0] y_w;
	logic signed [tmsl_pkg::SUM_W-1:0] z_w;
	logic signed [tmsl_pkg::SUM_W-1:0] r_w;
	logic [tmsl_pkg::HELD_N-1:0][tmsl_pkg::SPEED_W-1:0] tgt;

	// handshake control
	assign out_free  = !out_valid_q || pulse.ready;
	assign advance   = valid_s1 && out_free;
	assign cmd.ready = !valid_s1 || out_free;
	assign cmd_take  = cmd.valid && cmd.ready;
	assign cfg.ready = 1'b1;

	// register writes, out-of-range index ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_limit_q  <= tmsl_pkg::SPEED_LIMIT_RST;
			jerk_step_q    <= tmsl_pkg::JERK_STEP_RST;
			reverse_mask_q <= tmsl_pkg::REVERSE_MASK_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				tmsl_pkg::REG_SPEED_LIMIT:  speed_limit_q  <= cfg.data[tmsl_pkg::LIMIT_W-1:0];
				tmsl_pkg::REG_JERK_STEP:    jerk_step_q    <= cfg.data[tmsl_pkg::JERK_W-1:0];
				tmsl_pkg::REG_REVERSE_MASK: reverse_mask_q <= cfg.data[tmsl_pkg::MASK_W-1:0];
				default: ;
			endcase
		end
	end

	// input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (cmd_take) begin
			x_s1 <= cmd.axis_x;
			y_s1 <= cmd.axis_y;
			z_s1 <= cmd.axis_z;
			r_s1 <= cmd.axis_r;
		end
	end

	// mix, clamp and slew
	always_comb begin
		x_w = tmsl_pkg::SUM_W'(x_s1);
		y_w = tmsl_pkg::SUM_W'(y_s1);
		z_w = tmsl_pkg::SUM_W'(z_s1);
		r_w = tmsl_pkg::SUM_W'(r_s1);
		tgt[tmsl_pkg::H_A] = tmsl_pkg::clamp_speed(y_w + x_w + r_w, speed_limit_q);
		tgt[tmsl_pkg::H_B] = tmsl_pkg::clamp_speed(y_w - x_w - r_w, speed_limit_q);
		tgt[tmsl_pkg::H_E] = tmsl_pkg::clamp_speed(x_w - y_w - r_w, speed_limit_q);
		tgt[tmsl_pkg::H_F] = tmsl_pkg::clamp_speed(r_w - x_w - y_w, speed_limit_q);
		tgt[tmsl_pkg::H_Z] = tmsl_pkg::clamp_speed(z_w, speed_limit_q);
		for (int i = 0; i < tmsl_pkg::HELD_N; i++) begin
			held_nxt[i] = tmsl_pkg::slew_speed(held_q[i], tgt[i], jerk_step_q);
		end
	end

	// held speeds and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				held_q <= held_nxt;
			end
			if (out_free) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (advance) begin
			pulse_a_q <= tmsl_pkg::pulse_width(held_nxt[tmsl_pkg::H_A],
				reverse_mask_q[tmsl_pkg::MOT_A]);
			pulse_b_q <= tmsl_pkg::pulse_width(held_nxt[tmsl_pkg::H_B],
				reverse_mask_q[tmsl_pkg::MOT_B]);
			pulse_c_q <= tmsl_pkg::pulse_width(held_nxt[tmsl_pkg::H_Z],
				reverse_mask_q[tmsl_pkg::MOT_C]);
			pulse_d_q <= tmsl_pkg::pulse_width(held_nxt[tmsl_pkg::H_Z],
				reverse_mask_q[tmsl_pkg::MOT_D]);
			pulse_e_q <= tmsl_pkg::pulse_width(held_nxt[tmsl_pkg::H_E],
				reverse_mask_q[tmsl_pkg::MOT_E]);
			pulse_f_q <= tmsl_pkg::pulse_width(held_nxt[tmsl_pkg::H_F],
				reverse_mask_q[tmsl_pkg::MOT_F]);
		end
	end

	assign pulse.valid   = out_valid_q;
	assign pulse.pulse_a = pulse_a_q;
	assign pulse.pulse_b = pulse_b_q;
	assign pulse.pulse_c = pulse_c_q;
	assign pulse.pulse_d = pulse_d_q;
	assign pulse.pulse_e = pulse_e_q;
	assign pulse.pulse_f = pulse_f_q;

	// held speeds move only when an item passes into the result register
	`TMSL_ASSERT_NXT(a_held_only_on_advance, clk, arst_n, !advance, $stable(held_q))
	// an item that leaves the input register shows up as a result
	`TMSL_ASSERT_NXT(a_advance_gives_result, clk, arst_n, advance, out_valid_q)
	// an empty input register never back-pressures the command side
	`TMSL_ASSERT_IMP(a_empty_s1_ready, clk, arst_n, !valid_s1, cmd.ready)
	// an accepted item is held in the input register next cycle
	`TMSL_ASSERT_NXT(a_take_fills_s1, clk, arst_n, cmd_take, valid_s1)

endmodule
